FILE: src/msp_frame_check_and_reply_macros.svh
// Assertion macros shared by the frame checker modules.
`ifndef MSP_FRAME_CHECK_AND_REPLY_MACROS_SVH
`define MSP_FRAME_CHECK_AND_REPLY_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSP_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/msp_pkg.sv
package msp_pkg;

    // Frame geometry.
    localparam int PAYLOAD_BYTES = 20;
    localparam int HDR_BYTES     = 8;
    localparam int HDR_STORE     = 6;
    localparam int FRAME_BYTES   = HDR_BYTES + PAYLOAD_BYTES + 1;
    localparam int CRC_POS       = HDR_BYTES + PAYLOAD_BYTES;
    localparam int REPLY_BYTES   = PAYLOAD_BYTES + 9;

    // Widths derived from the geometry.
    localparam int POS_W  = $clog2(FRAME_BYTES);
    localparam int RPL_W  = $clog2(REPLY_BYTES);
    localparam int PAY_AW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int HDR_AW = $clog2(HDR_STORE);

    // CRC-8 DVB-S2.
    localparam logic [7:0] CRC_POLY = 8'hD5;
    localparam int         CRC_CNT_W = 4;
    localparam logic [CRC_CNT_W-1:0] CRC_BITS = CRC_CNT_W'(8);

    // Start-of-frame characters.
    localparam logic [7:0] SOF_FIRST  = 8'h24;
    localparam logic [7:0] SOF_SECOND = 8'h58;

    // Configuration register indexes and reset values.
    localparam logic [7:0] CFG_HDR_FIRST  = 8'd0;
    localparam logic [7:0] CFG_HDR_SECOND = 8'd1;
    localparam logic [7:0] RST_HDR_FIRST  = 8'd36;
    localparam logic [7:0] RST_HDR_SECOND = 8'd88;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_RX_IDLE,
        ST_RX_CRC,
        ST_TX_FETCH,
        ST_TX_LOAD,
        ST_TX_CRC
    } t_state;

    // Command to the shared serial CRC unit.
    typedef struct packed {
        logic       start;
        logic       clear;
        logic [7:0] data;
    } t_crc_cmd;

    // Status from the shared serial CRC unit.
    typedef struct packed {
        logic       busy;
        logic [7:0] crc;
    } t_crc_sts;

endpackage

FILE: src/msp_crc_unit.sv
`include "msp_frame_check_and_reply_macros.svh"

module msp_crc_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  msp_pkg::t_crc_cmd i_cmd,
    output msp_pkg::t_crc_sts o_sts
);
    import msp_pkg::*;

    logic [7:0]           r_acc, n_acc;
    logic [CRC_CNT_W-1:0] r_cnt, n_cnt;

    // A start folds the new byte into the accumulator; each busy cycle runs one bit step.
    always_comb begin
        n_acc = r_acc;
        n_cnt = r_cnt;
        if (i_cmd.start) begin
            n_acc = (i_cmd.clear ? 8'h00 : r_acc) ^ i_cmd.data;
            n_cnt = CRC_BITS;
        end else if (r_cnt != '0) begin
            n_acc = r_acc[7] ? ({r_acc[6:0], 1'b0} ^ CRC_POLY) : {r_acc[6:0], 1'b0};
            n_cnt = r_cnt - CRC_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 8'h00;
            r_cnt <= '0;
        end else begin
            r_acc <= n_acc;
            r_cnt <= n_cnt;
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.crc  = r_acc;

    `MSP_ASSERT_SAME(a_crc_start_idle, i_clk, i_rst_n, i_cmd.start, !o_sts.busy, "start while busy")
    `MSP_ASSERT_NEXT(a_crc_busy_next, i_clk, i_rst_n, i_cmd.start, o_sts.busy, "idle after start")
    `MSP_ASSERT_SAME(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CRC_BITS, "count out of range")

endmodule

FILE: src/msp_frame_check_and_reply.sv
// Channel   | Direction | Payload (lowest bit first)                               | Handshake
// ----------+-----------+----------------------------------------------------------+--------------
// s_t*      | in        | tdata: rx_byte[7:0]                                       | tvalid/tready
// m_t*      | out       | tdata: tx_byte, msg_type, msg_flags, function_id,         | tvalid/tready
//           |           |        payload_length; tlast: tx_last                     |
// i_cfg_*   | in        | index: register index, data: register value               | valid/ready
//
// A received byte is taken in the idle state and starts the shared serial CRC unit; the
// sequencer then waits through its bit steps until it sees the unit idle, with s_tready low.
// The CRC byte of a frame starts no CRC step; it is compared with the accumulated CRC.
// A valid frame's reply of 29 bytes is sent byte by byte: fetch, load and, but for the last
// byte, the CRC bit steps and an idle check; no input is taken meanwhile.
// A low m_tready on a held byte stalls the load step; the output register keeps its byte.
// Reset is synchronous and active low; configuration writes are taken in every cycle.
`include "msp_frame_check_and_reply_macros.svh"

module msp_frame_check_and_reply (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Received bytes.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // Reply bytes.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [7:0] tx_byte, [15:8] msg_type, [23:16] msg_flags,
                                   // [39:24] function_id, [55:40] payload_length
    output logic        m_tlast,   // tx_last
    // Configuration writes.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import msp_pkg::*;

    localparam logic [POS_W-1:0] POS_CRC    = POS_W'(CRC_POS);
    localparam logic [POS_W-1:0] POS_HDR    = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_SOF2   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_STORE  = POS_W'(2);
    localparam logic [RPL_W-1:0] IDX_HDR2   = RPL_W'(1);
    localparam logic [RPL_W-1:0] IDX_CNT_HI = RPL_W'(2);
    localparam logic [RPL_W-1:0] IDX_CNT_LO = RPL_W'(3);
    localparam logic [RPL_W-1:0] IDX_PAY    = RPL_W'(4);
    localparam logic [RPL_W-1:0] IDX_ZERO   = RPL_W'(4 + PAYLOAD_BYTES);
    localparam logic [RPL_W-1:0] IDX_LAST   = RPL_W'(REPLY_BYTES - 1);

    t_state r_state, n_state;

    logic [POS_W-1:0] r_pos;
    logic             r_start_ok;
    logic [7:0]       r_hdr [HDR_STORE];
    logic [7:0]       r_pay_mem [PAYLOAD_BYTES];
    logic [7:0]       r_rd_data;
    logic [RPL_W-1:0] r_tx_idx;
    logic [15:0]      r_counter;
    logic [7:0]       r_cfg_first, r_cfg_second;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic [7:0]  r_out_type, r_out_flags;
    logic [15:0] r_out_func, r_out_plen;

    t_crc_cmd crc_cmd;
    t_crc_sts crc_sts;

    logic             w_rx_acc;
    logic             w_out_free;
    logic             w_out_load;
    logic             w_last_load;
    logic             w_at_load;
    logic             w_frame_ok;
    logic             w_idx_step;
    logic [7:0]       w_tx_byte;
    logic [POS_W-1:0] w_hdr_off, w_pay_off;
    logic [RPL_W-1:0] w_rd_off;
    logic [HDR_AW-1:0] w_hdr_addr;
    logic [PAY_AW-1:0] w_wr_addr, w_rd_addr;

    msp_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (crc_cmd),
        .o_sts   (crc_sts)
    );

    assign w_rx_acc    = s_tvalid && s_tready;
    assign w_out_free  = !r_out_valid || m_tready;
    assign w_frame_ok  = r_start_ok && (crc_sts.crc == s_tdata);
    assign w_last_load = w_out_load && (r_tx_idx == IDX_LAST);
    assign w_at_load   = (r_state == ST_TX_LOAD);

    // Store addresses derived from the frame position and the reply index.
    assign w_hdr_off  = r_pos - POS_STORE;
    assign w_pay_off  = r_pos - POS_HDR;
    assign w_rd_off   = r_tx_idx - IDX_PAY;
    assign w_hdr_addr = w_hdr_off[HDR_AW-1:0];
    assign w_wr_addr  = w_pay_off[PAY_AW-1:0];
    assign w_rd_addr  = w_rd_off[PAY_AW-1:0];

    // Reply byte for the current index.
    always_comb begin
        if (r_tx_idx == '0) begin
            w_tx_byte = r_cfg_first;
        end else if (r_tx_idx == IDX_HDR2) begin
            w_tx_byte = r_cfg_second;
        end else if (r_tx_idx == IDX_CNT_HI) begin
            w_tx_byte = r_counter[15:8];
        end else if (r_tx_idx == IDX_CNT_LO) begin
            w_tx_byte = r_counter[7:0];
        end else if (r_tx_idx < IDX_ZERO) begin
            w_tx_byte = r_rd_data;
        end else if (r_tx_idx == IDX_LAST) begin
            w_tx_byte = crc_sts.crc;
        end else begin
            w_tx_byte = 8'h00;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_RX_IDLE: begin
                if (w_rx_acc) begin
                    if (r_pos != POS_CRC) begin
                        n_state = ST_RX_CRC;
                    end else if (w_frame_ok) begin
                        n_state = ST_TX_FETCH;
                    end
                end
            end
            ST_RX_CRC: begin
                if (!crc_sts.busy) begin
                    n_state = ST_RX_IDLE;
                end
            end
            ST_TX_FETCH: begin
                n_state = ST_TX_LOAD;
            end
            ST_TX_LOAD: begin
                if (w_out_free) begin
                    n_state = (r_tx_idx == IDX_LAST) ? ST_RX_IDLE : ST_TX_CRC;
                end
            end
            ST_TX_CRC: begin
                if (!crc_sts.busy) begin
                    n_state = ST_TX_FETCH;
                end
            end
            default: begin
                n_state = ST_RX_IDLE;
            end
        endcase
    end

    // Sequencer outputs: input handshake, CRC commands and output register load.
    always_comb begin
        s_tready      = 1'b0;
        crc_cmd.start = 1'b0;
        crc_cmd.clear = 1'b0;
        crc_cmd.data  = s_tdata;
        w_out_load    = 1'b0;
        w_idx_step    = 1'b0;
        case (r_state)
            ST_RX_IDLE: begin
                s_tready = 1'b1;
                if (w_rx_acc && (r_pos != POS_CRC)) begin
                    crc_cmd.start = 1'b1;
                    crc_cmd.clear = (r_pos == '0);
                end
            end
            ST_TX_LOAD: begin
                crc_cmd.data = w_tx_byte;
                if (w_out_free) begin
                    w_out_load    = 1'b1;
                    crc_cmd.start = (r_tx_idx != IDX_LAST);
                    crc_cmd.clear = (r_tx_idx == '0);
                end
            end
            ST_TX_CRC: begin
                w_idx_step = !crc_sts.busy;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RX_IDLE;
            r_pos      <= '0;
            r_start_ok <= 1'b0;
            r_tx_idx   <= '0;
            r_counter  <= 16'h0000;
        end else begin
            r_state <= n_state;
            if (w_rx_acc) begin
                if (r_pos == POS_CRC) begin
                    r_pos    <= '0;
                    r_tx_idx <= '0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
                if (r_pos == '0) begin
                    r_start_ok <= (s_tdata == SOF_FIRST);
                end else if (r_pos == POS_SOF2) begin
                    r_start_ok <= r_start_ok && (s_tdata == SOF_SECOND);
                end
            end
            if (w_idx_step) begin
                r_tx_idx <= r_tx_idx + RPL_W'(1);
            end
            if (w_last_load) begin
                r_counter <= r_counter + 16'd1;
            end
        end
    end

    // Header store and payload memory writes.
    always_ff @(posedge i_clk) begin
        if (w_rx_acc && (r_pos >= POS_STORE) && (r_pos < POS_HDR)) begin
            r_hdr[w_hdr_addr] <= s_tdata;
        end
        if (w_rx_acc && (r_pos >= POS_HDR) && (r_pos < POS_CRC)) begin
            r_pay_mem[w_wr_addr] <= s_tdata;
        end
    end

    // Registered payload read for the reply.
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_TX_FETCH) && (r_tx_idx >= IDX_PAY) && (r_tx_idx < IDX_ZERO)) begin
            r_rd_data <= r_pay_mem[w_rd_addr];
        end
    end

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_first  <= RST_HDR_FIRST;
            r_cfg_second <= RST_HDR_SECOND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_HDR_FIRST:  r_cfg_first  <= i_cfg_data;
                CFG_HDR_SECOND: r_cfg_second <= i_cfg_data;
                default: begin
                    r_cfg_first <= r_cfg_first;
                end
            endcase
        end
    end

    // Output register: valid flag under reset, payload loaded with each reply byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_byte  <= w_tx_byte;
            r_out_last  <= (r_tx_idx == IDX_LAST);
            r_out_type  <= r_hdr[0];
            r_out_flags <= r_hdr[1];
            r_out_func  <= {r_hdr[3], r_hdr[2]};
            r_out_plen  <= {r_hdr[5], r_hdr[4]};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tlast  = r_out_last;
    assign m_tdata  = {r_out_plen, r_out_func, r_out_flags, r_out_type, r_out_byte};

    `MSP_ASSERT_SAME(a_pos_range, i_clk, i_rst_n, 1'b1, r_pos <= POS_CRC, "position out of range")
    `MSP_ASSERT_SAME(a_load_idle, i_clk, i_rst_n, w_at_load, !crc_sts.busy, "load while CRC busy")
    `MSP_ASSERT_NEXT(a_cnt_hold, i_clk, i_rst_n, !w_last_load, $stable(r_counter), "counter moved")
    `MSP_ASSERT_SAME(a_idx_range, i_clk, i_rst_n, 1'b1, r_tx_idx <= IDX_LAST, "index out of range")

endmodule
